>>> sv/tweb_pkg.sv
// ---------------------------------------------------------------------------
// Event builder package
// Types, widths, codes and helpers shared by the event builder modules.
// ---------------------------------------------------------------------------
package tweb_pkg;

   localparam int TS_W       = 48;
   localparam int CTS_W      = 49;
   localparam int COUNT_W    = 16;
   localparam int PULSE_W    = 32;
   localparam int GAP_W      = 20;
   localparam int STEP_W     = 16;
   localparam int BOARD_W    = 6;
   localparam int CHAN_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;

   localparam logic [GAP_W-1:0]  EVENT_GAP_RESET        = 20'd2200;
   localparam logic [GAP_W-1:0]  MUX_GAP_RESET          = 20'd2500;
   localparam logic [STEP_W-1:0] MUX_STEP_RESET         = 16'd2000;
   localparam logic [STEP_W-1:0] PULSER_THRESHOLD_RESET = 16'd1024;

   localparam logic ACTION_HIT = 1'b0;
   localparam logic ACTION_END = 1'b1;

   typedef enum logic [1:0] {
      RANGE_DECAY   = 2'd0,
      RANGE_IMPLANT = 2'd1,
      RANGE_OTHER   = 2'd2,
      RANGE_CORR    = 2'd3
   } range_type;

   typedef enum logic [1:0] {
      CLASS_DROPPED = 2'd0,
      CLASS_IMPLANT = 2'd1,
      CLASS_PULSER  = 2'd2,
      CLASS_DECAY   = 2'd3
   } class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EVENT_GAP        = 2'd0,
      CSR_MUX_GAP          = 2'd1,
      CSR_MUX_STEP         = 2'd2,
      CSR_PULSER_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAP_W-1:0]  event_gap;
      logic [GAP_W-1:0]  mux_gap;
      logic [STEP_W-1:0] mux_step;
      logic [STEP_W-1:0] pulser_threshold;
   } cfg_type;

   typedef struct packed {
      logic               action;
      logic [BOARD_W-1:0] board_number;
      logic [CHAN_W-1:0]  channel;
      range_type          energy_range;
      logic [TS_W-1:0]    timestamp;
   } hit_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TS_W-1:0]    last_time;
   } mux_entry_type;

   typedef struct packed {
      logic               closed;
      logic               send_correlation;
      class_type          closed_class;
      logic [COUNT_W-1:0] decay_hits;
      logic [COUNT_W-1:0] implant_hits;
      logic [COUNT_W-1:0] correlation_hits;
   } close_info_type;

   function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

>>> sv/tweb_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ---------------------------------------------------------------------------
module tweb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tweb_mux_corr.sv
// ---------------------------------------------------------------------------
// Multiplexer timestamp correction
// Per board and converter hit table with entry valid bits, write forwarding
// and the timestamp correction of one hit.
// ---------------------------------------------------------------------------
module tweb_mux_corr #(
   parameter int NUM_BOARDS           = 32,
   parameter int CONVERTERS_PER_BOARD = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  tweb_pkg::hit_type              req_hit,
   input  logic                           fire_hit,
   input  logic                           closing,
   input  logic [tweb_pkg::TS_W-1:0]      timestamp,
   input  tweb_pkg::cfg_type              cfg,
   output logic [tweb_pkg::CTS_W-1:0]     corrected_timestamp
);

   localparam int DEPTH = NUM_BOARDS * CONVERTERS_PER_BOARD;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = $bits(tweb_pkg::mux_entry_type);

   logic [tweb_pkg::BOARD_W-1:0] board_m1;
   logic [1:0]                   conv;
   logic [15:0]                  idx_wide;
   logic                         req_elig;

   logic [IDX_W-1:0] idx_ff;
   logic             elig_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             wr_seen_ff;
   logic [IDX_W-1:0] wr_idx_ff;
   tweb_pkg::mux_entry_type wr_data_ff;

   logic [ENTRY_W-1:0]      rd_raw;
   tweb_pkg::mux_entry_type entry;
   tweb_pkg::mux_entry_type new_entry;
   logic                    entry_live;
   logic [tweb_pkg::COUNT_W-1:0] cnt;
   logic [tweb_pkg::TS_W-1:0]    last;
   logic [tweb_pkg::TS_W-1:0]    gap;
   logic [31:0]                  shift;
   logic                         wr_en;

   always_comb begin
      board_m1 = req_hit.board_number - 1'b1;
      conv     = req_hit.channel[5:4];
      idx_wide = 16'(board_m1) * 16'(CONVERTERS_PER_BOARD) + 16'(conv);
      req_elig = (req_hit.energy_range != tweb_pkg::RANGE_CORR) &&
                 (req_hit.board_number != '0) &&
                 (32'(req_hit.board_number) <= 32'(NUM_BOARDS)) &&
                 (32'(conv) < 32'(CONVERTERS_PER_BOARD));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff  <= idx_wide[IDX_W-1:0];
         elig_ff <= req_elig;
      end
   end

   tweb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (idx_wide[IDX_W-1:0]),
      .rd_data (rd_raw)
   );

   always_comb begin
      entry      = (wr_seen_ff && (wr_idx_ff == idx_ff)) ? wr_data_ff
                                                          : tweb_pkg::mux_entry_type'(rd_raw);
      entry_live = elig_ff && valid_ff[idx_ff] && !closing;
      cnt        = entry_live ? entry.count : '0;
      last       = entry_live ? entry.last_time : '0;
      gap        = timestamp - last;
      if ((last != '0) && (gap > 48'(cfg.mux_gap))) begin
         cnt = '0;
      end
      new_entry.count     = tweb_pkg::sat_inc16(cnt);
      new_entry.last_time = timestamp;
      wr_en  = fire_hit && elig_ff;
      shift  = 32'(cfg.mux_step) * 32'(cnt);
      corrected_timestamp = elig_ff ? ({1'b0, timestamp} - 49'(shift))
                                    : {1'b0, timestamp};
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire_hit && closing) begin
         valid_in = '0;
      end
      if (wr_en) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         wr_seen_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (wr_en) begin
            wr_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_idx_ff  <= idx_ff;
         wr_data_ff <= new_entry;
      end
   end

endmodule

>>> sv/tweb_event_close.sv
// ---------------------------------------------------------------------------
// Event window and classification
// Tracks the open event, decides when a hit closes it and classifies the
// closed event; keeps the saturating pulser count.
// ---------------------------------------------------------------------------
module tweb_event_close (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire_hit,
   input  tweb_pkg::range_type             energy_range,
   input  logic [tweb_pkg::TS_W-1:0]       timestamp,
   input  tweb_pkg::cfg_type               cfg,
   output logic                            closing,
   output tweb_pkg::close_info_type        close_info,
   output logic [tweb_pkg::PULSE_W-1:0]    pulser_total
);

   logic [tweb_pkg::TS_W-1:0]    prev_time_ff;
   logic [tweb_pkg::COUNT_W-1:0] decay_ff, implant_ff, corr_ff;
   logic [tweb_pkg::COUNT_W-1:0] decay_in, implant_in, corr_in;
   logic [tweb_pkg::PULSE_W-1:0] pulser_ff, pulser_in;
   logic [tweb_pkg::TS_W-1:0]    gap;
   tweb_pkg::class_type          cls;

   always_comb begin
      gap     = timestamp - prev_time_ff;
      closing = (prev_time_ff != '0) && (gap >= 48'(cfg.event_gap));

      if (implant_ff > 16'd1) begin
         cls = tweb_pkg::CLASS_IMPLANT;
      end else if (decay_ff > cfg.pulser_threshold) begin
         cls = tweb_pkg::CLASS_PULSER;
      end else if (decay_ff > 16'd1) begin
         cls = tweb_pkg::CLASS_DECAY;
      end else begin
         cls = tweb_pkg::CLASS_DROPPED;
      end

      close_info = '0;
      if (closing) begin
         close_info.closed           = 1'b1;
         close_info.send_correlation = (corr_ff != '0);
         close_info.closed_class     = cls;
         close_info.decay_hits       = decay_ff;
         close_info.implant_hits     = implant_ff;
         close_info.correlation_hits = corr_ff;
      end

      pulser_in = pulser_ff;
      if (fire_hit && closing && (cls == tweb_pkg::CLASS_PULSER) && (pulser_ff != '1)) begin
         pulser_in = pulser_ff + 1'b1;
      end

      decay_in   = closing ? '0 : decay_ff;
      implant_in = closing ? '0 : implant_ff;
      corr_in    = closing ? '0 : corr_ff;
      case (energy_range)
         tweb_pkg::RANGE_DECAY:   decay_in   = tweb_pkg::sat_inc16(decay_in);
         tweb_pkg::RANGE_IMPLANT: implant_in = tweb_pkg::sat_inc16(implant_in);
         tweb_pkg::RANGE_CORR:    corr_in    = tweb_pkg::sat_inc16(corr_in);
         default: ;
      endcase
   end

   assign pulser_total = pulser_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         decay_ff     <= '0;
         implant_ff   <= '0;
         corr_ff      <= '0;
         pulser_ff    <= '0;
      end else if (fire_hit) begin
         prev_time_ff <= timestamp;
         decay_ff     <= decay_in;
         implant_ff   <= implant_in;
         corr_ff      <= corr_in;
         pulser_ff    <= pulser_in;
      end
   end

endmodule

>>> sv/time_window_event_builder_unit.sv
// ---------------------------------------------------------------------------
// Time window event builder
// Builds events from timestamped detector hits, classifies closed events and
// corrects multiplexer timestamps per board and converter.
// ---------------------------------------------------------------------------
// Request beats are held in the item register, response beats in rsp_data_ff.
// One beat per cycle unless rsp_tready stalls; table read-modify-write is a RAM
// read at acceptance and a write when the hit fires, with forwarding.
// Reset: synchronous; clears the open event, the pulser count, the table valid
// bits and the pipeline, and restores register defaults. No clearing pass.
module time_window_event_builder_unit #(
   parameter int NUM_BOARDS           = 32,
   parameter int CONVERTERS_PER_BOARD = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // board_number[5:0], channel[11:6], energy_range[13:12], timestamp[61:14]
   input  logic [tweb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // corrected_timestamp[48:0], hit_list[50:49], event_closed[51],
   // send_correlation[52], closed_class[54:53], closed_decay_hits[70:55],
   // closed_implant_hits[86:71], closed_correlation_hits[102:87],
   // pulser_total[134:103]
   output logic [tweb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // end_of_run[0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [tweb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tweb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   tweb_pkg::cfg_type cfg_ff;
   tweb_pkg::hit_type req_hit;
   tweb_pkg::hit_type item_ff;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic [tweb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff;
   logic              accept;
   logic              fire;
   logic              fire_hit;
   logic              closing;
   tweb_pkg::close_info_type close_info;
   logic [tweb_pkg::PULSE_W-1:0] pulser_total;
   logic [tweb_pkg::CTS_W-1:0]   corrected_timestamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.event_gap        <= tweb_pkg::EVENT_GAP_RESET;
         cfg_ff.mux_gap          <= tweb_pkg::MUX_GAP_RESET;
         cfg_ff.mux_step         <= tweb_pkg::MUX_STEP_RESET;
         cfg_ff.pulser_threshold <= tweb_pkg::PULSER_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (tweb_pkg::csr_index_type'(csr_index))
            tweb_pkg::CSR_EVENT_GAP:        cfg_ff.event_gap        <= csr_wdata;
            tweb_pkg::CSR_MUX_GAP:          cfg_ff.mux_gap          <= csr_wdata;
            tweb_pkg::CSR_MUX_STEP:         cfg_ff.mux_step         <= csr_wdata[15:0];
            tweb_pkg::CSR_PULSER_THRESHOLD: cfg_ff.pulser_threshold <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_hit.action       = req_tuser;
      req_hit.board_number = req_tdata[5:0];
      req_hit.channel      = req_tdata[11:6];
      req_hit.energy_range = tweb_pkg::range_type'(req_tdata[13:12]);
      req_hit.timestamp    = req_tdata[61:14];
   end

   assign fire       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;
   assign fire_hit   = fire && (item_ff.action == tweb_pkg::ACTION_HIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_hit;
      end
   end

   tweb_event_close u_event (
      .clock        (clock),
      .reset        (reset),
      .fire_hit     (fire_hit),
      .energy_range (item_ff.energy_range),
      .timestamp    (item_ff.timestamp),
      .cfg          (cfg_ff),
      .closing      (closing),
      .close_info   (close_info),
      .pulser_total (pulser_total)
   );

   tweb_mux_corr #(
      .NUM_BOARDS           (NUM_BOARDS),
      .CONVERTERS_PER_BOARD (CONVERTERS_PER_BOARD)
   ) u_mux (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_hit             (req_hit),
      .fire_hit            (fire_hit),
      .closing             (closing),
      .timestamp           (item_ff.timestamp),
      .cfg                 (cfg_ff),
      .corrected_timestamp (corrected_timestamp)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[134:103] = pulser_total;
      if (item_ff.action == tweb_pkg::ACTION_END) begin
         rsp_data_in[50:49] = tweb_pkg::RANGE_OTHER;
      end else begin
         rsp_data_in[48:0]   = corrected_timestamp;
         rsp_data_in[50:49]  = item_ff.energy_range;
         rsp_data_in[51]     = close_info.closed;
         rsp_data_in[52]     = close_info.send_correlation;
         rsp_data_in[54:53]  = close_info.closed_class;
         rsp_data_in[70:55]  = close_info.decay_hits;
         rsp_data_in[86:71]  = close_info.implant_hits;
         rsp_data_in[102:87] = close_info.correlation_hits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= (item_ff.action == tweb_pkg::ACTION_END);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
